FILE: rtl/core/systematic_resampler_assert.svh
// Assertion macros for the resampler core. Clock is i_clk, reset is i_rst_n.
`ifndef SYSTEMATIC_RESAMPLER_ASSERT_SVH
`define SYSTEMATIC_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define SR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sr_pkg.sv
package sr_pkg;

    localparam int WGT_W = 16;   // weight and offset, Q0.16
    localparam int IDX_W = 9;    // index word width

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TGT  = 3'b010,
        S_SRCH = 3'b100
    } t_state;

endpackage

FILE: rtl/core/systematic_resampler.sv
// Systematic resampler for a particle filter. A load word (i_action = load)
// adds its Q0.16 weight to a running total and stores the new cumulative sum;
// it never raises busy. The first draw word after a load phase latches
// i_offset as the fractional start. Each draw returns the index of the first
// particle k with cum_k*N*65536 >= (offset + j*65536)*total, where N is the
// number of loaded weights and total their exact sum. A draw holds busy
// through target setup and a search whose pointer steps one entry at a time
// through the single read port of the cumulative store; the pointer only
// moves forward within a set. A draw with no weights loaded, or beyond N
// draws, skips the search and returns overrun with index 0. Loading after a
// draw phase starts a new set; loads beyond MAX_PARTICLES are dropped. The
// store needs no clearing pass after reset. Results are shown for exactly
// one cycle on o_valid and cannot be held off by the receiver.
module systematic_resampler #(
    parameter int MAX_PARTICLES = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [sr_pkg::WGT_W-1:0]  i_weight,
    input  logic [sr_pkg::WGT_W-1:0]  i_offset,
    output logic                      o_valid,
    output logic [sr_pkg::IDX_W-1:0]  o_index,
    output logic                      o_last_draw,
    output logic                      o_overrun
);
    import sr_pkg::*;

    `include "systematic_resampler_assert.svh"

    // store address, count and cumulative-sum widths
    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int NW = $clog2(MAX_PARTICLES + 1);
    localparam int CW = WGT_W + AW;
    localparam int TW = CW + NW + WGT_W;

    // cumulative store
    logic [CW-1:0] mem [MAX_PARTICLES];

    t_state         r_state, n_state;
    logic [NW-1:0]  r_cnt,   n_cnt;
    logic [CW-1:0]  r_total, n_total;
    logic [NW-1:0]  r_dc,    n_dc;
    logic [AW-1:0]  r_ptr,   n_ptr;
    logic [WGT_W-1:0] r_offset, n_offset;
    logic           r_phase, n_phase;
    logic [TW-1:0]  r_target;
    logic [CW-1:0]  r_rdata;
    logic           r_valid, n_valid;
    logic [IDX_W-1:0] r_index, n_index;
    logic           r_last,  n_last;
    logic           r_ovr,   n_ovr;

    logic           w_accept;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic           w_rd_en;
    logic [AW-1:0]  w_rd_addr;
    logic [NW+WGT_W-1:0] w_pos;
    logic [TW-1:0]  w_target;
    logic [CW+NW-1:0] w_prod;
    logic           w_below;
    logic           w_more;
    logic           w_advance;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // target = (offset + j*65536) * total, registered once per draw
    assign w_pos    = {r_dc, {WGT_W{1'b0}}} + (NW + WGT_W)'(r_offset);
    assign w_target = TW'(w_pos) * TW'(r_total);

    // scaled cumulative sum of the entry under the pointer
    assign w_prod    = (CW + NW)'(r_rdata) * (CW + NW)'(r_cnt);
    assign w_below   = {w_prod, {WGT_W{1'b0}}} < r_target;
    assign w_more    = NW'(r_ptr) < (r_cnt - NW'(1));
    assign w_advance = (r_state == S_SRCH) && w_more && w_below;

    // read ahead: current pointer on entry, next entry when stepping
    assign w_rd_en   = (r_state == S_TGT) || w_advance;
    assign w_rd_addr = (r_state == S_TGT) ? r_ptr : r_ptr + AW'(1);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_total  = r_total;
        n_dc     = r_dc;
        n_ptr    = r_ptr;
        n_offset = r_offset;
        n_phase  = r_phase;
        n_valid  = 1'b0;
        n_index  = r_index;
        n_last   = r_last;
        n_ovr    = r_ovr;
        w_wr_en   = 1'b0;
        w_wr_addr = AW'(r_cnt);
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_action == ACT_LOAD) begin
                    // a load after drawing opens a new set
                    if (r_phase) begin
                        n_cnt   = '0;
                        n_total = '0;
                        n_dc    = '0;
                        n_ptr   = '0;
                        n_phase = 1'b0;
                    end
                    if (n_cnt < NW'(MAX_PARTICLES)) begin
                        n_total   = n_total + CW'(i_weight);
                        w_wr_en   = 1'b1;
                        w_wr_addr = n_cnt[AW-1:0];
                        n_cnt     = n_cnt + NW'(1);
                    end
                end else if (w_accept) begin
                    if (!r_phase) begin
                        n_phase  = 1'b1;
                        n_offset = i_offset;
                        n_dc     = '0;
                        n_ptr    = '0;
                    end
                    n_state = S_TGT;
                end
            end
            S_TGT: begin
                if (r_cnt == '0 || r_dc >= r_cnt) begin
                    n_valid = 1'b1;
                    n_index = '0;
                    n_last  = 1'b0;
                    n_ovr   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (w_advance) begin
                    n_ptr = r_ptr + AW'(1);
                end else begin
                    n_valid = 1'b1;
                    n_index = IDX_W'(r_ptr);
                    n_last  = (r_dc + NW'(1)) == r_cnt;
                    n_ovr   = 1'b0;
                    n_dc    = r_dc + NW'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_dc     <= '0;
            r_ptr    <= '0;
            r_offset <= '0;
            r_phase  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_dc     <= n_dc;
            r_ptr    <= n_ptr;
            r_offset <= n_offset;
            r_phase  <= n_phase;
            r_valid  <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_last  <= n_last;
        r_ovr   <= n_ovr;
        if (r_state == S_TGT) begin
            r_target <= w_target;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= n_total;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    assign o_valid     = r_valid;
    assign o_index     = r_index;
    assign o_last_draw = r_last;
    assign o_overrun   = r_ovr;

    // a draw always enters target setup next
    `SR_ASSERT_NEXT(a_draw_to_tgt, w_accept && i_action == ACT_DRAW, r_state == S_TGT, "draw not started")
    // a result only follows a busy cycle
    `SR_ASSERT_NOW(a_valid_after_busy, o_valid, $past(r_state != S_IDLE), "result without draw")
    // search pointer stays inside the loaded set
    `SR_ASSERT_NOW(a_ptr_bound, r_phase && r_cnt != '0, NW'(r_ptr) < r_cnt, "pointer past set")
    // a load never leaves the block busy
    `SR_ASSERT_NEXT(a_load_idle, w_accept && i_action == ACT_LOAD, !busy && !o_valid, "load busy")

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sr_pkg::*;

    localparam int NPART     = 512;      // default store depth of the DUT
    localparam int CYC_LIMIT = 600000;   // generous run limit
    localparam int TAIL_CYC  = 16;       // settle time after the last result
    localparam int FULL_PULL = 40;       // draws taken from the full set

    // one drawn result word as seen on the output ports
    typedef struct {
        logic [IDX_W-1:0] index;
        logic             last_draw;
        logic             overrun;
    } t_draw_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_action = ACT_LOAD;
    logic [WGT_W-1:0]  i_weight = '0;
    logic [WGT_W-1:0]  i_offset = '0;
    logic              o_valid;
    logic [IDX_W-1:0]  o_index;
    logic              o_last_draw;
    logic              o_overrun;

    int         n_errors = 0;
    int         n_cycles = 0;
    bit         idle_on = 1'b0;
    t_draw_word pending_draws[$];

    // shadow copy of the resampler state
    logic [24:0]      cum_sum[NPART];
    logic [9:0]       n_loaded = '0;
    logic [24:0]      wsum = '0;
    logic [9:0]       n_drawn = '0;
    logic [IDX_W-1:0] walk_ptr = '0;
    logic [WGT_W-1:0] start_frac = '0;
    bit               drawing = 1'b0;

    systematic_resampler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_weight    (i_weight),
        .i_offset    (i_offset),
        .o_valid     (o_valid),
        .o_index     (o_index),
        .o_last_draw (o_last_draw),
        .o_overrun   (o_overrun)
    );

    always #5 i_clk = ~i_clk;

    // run limit: catches a hung handshake or a lost result
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYC_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("testbench failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // append one expected result word at the tail of the queue
    function automatic void add_expected(input t_draw_word res);
        pending_draws = {pending_draws, res};
    endfunction

    // Work out what one accepted word does to the shadow state and queue the
    // result word it causes. A load causes none.
    function automatic void predict_word(input logic act, input logic [WGT_W-1:0] w,
                                         input logic [WGT_W-1:0] off);
        t_draw_word  res;
        logic [63:0] goal;
        logic [9:0]  last;
        if (act == ACT_LOAD) begin
            // a load after drawing closes the old set
            if (drawing) begin
                n_loaded = '0;
                wsum     = '0;
                n_drawn  = '0;
                walk_ptr = '0;
                drawing  = 1'b0;
            end
            // full store: weight dropped
            if (n_loaded < 10'(NPART)) begin
                wsum                    = wsum + 25'(w);
                cum_sum[n_loaded[8:0]]  = wsum;
                n_loaded                = n_loaded + 10'd1;
            end
            return;
        end
        // first draw of a set latches the fractional start
        if (!drawing) begin
            drawing    = 1'b1;
            start_frac = off;
            n_drawn    = '0;
            walk_ptr   = '0;
        end
        if (n_loaded == 10'd0 || n_drawn >= n_loaded) begin
            res.index     = '0;
            res.last_draw = 1'b0;
            res.overrun   = 1'b1;
            add_expected(res);
            return;
        end
        // target = (offset + j*65536) * total, compared against cum*N*65536
        goal = (64'(start_frac) + (64'(n_drawn) << 16)) * 64'(wsum);
        last = n_loaded - 10'd1;
        while (10'(walk_ptr) < last &&
               ((64'(cum_sum[walk_ptr]) * 64'(n_loaded)) << 16) < goal)
            walk_ptr = walk_ptr + IDX_W'(1);
        res.index     = walk_ptr;
        res.last_draw = (n_drawn + 10'd1 == n_loaded);
        res.overrun   = 1'b0;
        n_drawn       = n_drawn + 10'd1;
        add_expected(res);
    endfunction

    // Drive one word at the falling edge and hold it until start meets !busy.
    // start stays high afterwards; the next word or an idle gap replaces it.
    task automatic send_word(input logic act, input logic [WGT_W-1:0] w,
                             input logic [WGT_W-1:0] off);
        @(negedge i_clk);
        start    <= 1'b1;
        i_action <= act;
        i_weight <= w;
        i_offset <= off;
        do @(posedge i_clk); while (busy);
        predict_word(act, w, off);
    endtask

    // random sender gap, on one call in four while idling is on
    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 19);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // sender holds off until every queued result word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_draws.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [WGT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WGT_W'($urandom_range(0, 15));
            default: return WGT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] rand_offset();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return WGT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic load_w(input logic [WGT_W-1:0] w);
        idle_gap();
        send_word(ACT_LOAD, w, WGT_W'($urandom_range(0, 65535)));
    endtask

    task automatic draw_w(input logic [WGT_W-1:0] off);
        idle_gap();
        send_word(ACT_DRAW, WGT_W'($urandom_range(0, 65535)), off);
    endtask

    // Result checker: every strobe pops the oldest expectation.
    always @(posedge i_clk) begin
        t_draw_word want;
        if (i_rst_n && o_valid) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("o_valid with no result due", 1, 0);
            end else begin
                want = pending_draws.pop_front();
                if (o_index !== want.index)
                    report_mismatch("index", int'(o_index), int'(want.index));
                if (o_last_draw !== want.last_draw)
                    report_mismatch("last_draw", int'(o_last_draw), int'(want.last_draw));
                if (o_overrun !== want.overrun)
                    report_mismatch("overrun", int'(o_overrun), int'(want.overrun));
            end
        end
    end

    // Directed corners: empty draws, one-weight and zero-total sets,
    // weight extremes, offset extremes, draws past N, reload mid-draw.
    task automatic test_directed();
        idle_on = 1'b0;
        // nothing loaded: both draws overrun, offset extremes
        draw_w('0);
        draw_w('1);
        // load in draw phase starts a set of one zero weight
        load_w('0);
        draw_w('1);
        draw_w('0);                 // beyond N
        // mixed extremes, N = 4, offset 0
        load_w('1);
        load_w('0);
        load_w('1);
        load_w(16'd1);
        repeat (4) draw_w('0);
        draw_w('1);                 // beyond N
        // zero total: every draw picks particle 0
        repeat (3) load_w('0);
        repeat (3) draw_w(16'd12345);
        // largest offset, then a reload before the set is drawn out
        load_w('1);
        load_w('1);
        draw_w('1);
        load_w(16'h8000);
        draw_w('0);
    endtask

    // Fill the store past its depth (extra weight dropped), draw the head of
    // the set; the next test's load cuts it short.
    task automatic test_full_store();
        idle_on = 1'b1;
        repeat (NPART + 1) load_w(rand_weight());
        repeat (FULL_PULL) draw_w(rand_offset());
    endtask

    // Sender pauses mid-set until the pipe is empty, then finishes the set.
    task automatic test_drain_pause();
        idle_on = 1'b1;
        repeat (8) load_w(rand_weight());
        repeat (4) draw_w(rand_offset());
        wait_drained();
        repeat (5) draw_w(rand_offset());
        wait_drained();
    endtask

    // Mostly whole sets with random content; some cut short, some drawn past
    // the end, some noise words. Sizes are mostly small, a few larger.
    task automatic test_random_sets(input int n_words, input bit with_idle);
        int sent;
        int n_set;
        int n_pull;
        logic [WGT_W-1:0] zero_mask;
        sent = 0;
        while (sent < n_words) begin
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 2) begin
                // noise word
                idle_gap();
                send_word(1'($urandom_range(0, 1)), rand_weight(), rand_offset());
                sent++;
            end else begin
                n_set = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                    : $urandom_range(1, 16);
                // occasionally an all-zero set
                zero_mask = ($urandom_range(0, 11) == 0) ? '0 : '1;
                repeat (n_set) load_w(rand_weight() & zero_mask);
                case ($urandom_range(0, 5))
                    0:       n_pull = $urandom_range(1, n_set);        // cut short
                    1:       n_pull = n_set + $urandom_range(1, 3);    // overrun
                    default: n_pull = n_set;
                endcase
                repeat (n_pull) draw_w(rand_offset());
                sent += n_set + n_pull;
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_store();
        test_drain_pause();
        test_random_sets(360, 1'b1);
        test_random_sets(100, 1'b0);     // closing stretch, no idling

        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (pending_draws.size() != 0) begin
            report_mismatch("outstanding result words", pending_draws.size(), 0);
        end

        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
